// ===== rtl/http_host_extractor_defines.svh =====
// assertion macros shared by the host extractor checker
`ifndef HTTP_HOST_EXTRACTOR_DEFINES_SVH
`define HTTP_HOST_EXTRACTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define HHE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define HHE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/hhe_pkg.sv =====
// shared constants, types and match tables of the http host extractor
package hhe_pkg;

   localparam int HOST_MAX          = 64;
   localparam int FRAME_MAX         = 2048;
   localparam int LINK_HEADER_BYTES = 14;

   localparam int POS_W  = $clog2(FRAME_MAX + 1);
   localparam int LEN_W  = $clog2(HOST_MAX + 1);
   localparam int ADDR_W = $clog2(HOST_MAX);

   localparam logic [7:0]  CHAR_CR    = 8'h0D;
   localparam logic [7:0]  CHAR_H     = 8'h48;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [31:0] SRC_RESET  = 32'h7F00_0001;

   // host capture phase, one-hot
   typedef enum logic [2:0] {
      PHASE_SEARCHING = 3'b001,
      PHASE_CAPTURING = 3'b010,
      PHASE_DONE      = 3'b100
   } host_phase_type;

   // emitter sequencer, one-hot
   typedef enum logic [1:0] {
      EMIT_IDLE = 2'b01,
      EMIT_RUN  = 2'b10
   } emit_state_type;

   // frame-end command from parser to emitter
   typedef struct packed {
      logic             start;
      logic             single;
      logic             too_long;
      logic [LEN_W-1:0] count;
   } emit_cmd_type;

   // "HTTP"
   function automatic logic [7:0] http_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h48;
         2'd1:    c = 8'h54;
         2'd2:    c = 8'h54;
         default: c = 8'h50;
      endcase
      return c;
   endfunction

   // "Host: "
   function automatic logic [7:0] host_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h48;
         3'd1:    c = 8'h6F;
         3'd2:    c = 8'h73;
         3'd3:    c = 8'h74;
         3'd4:    c = 8'h3A;
         3'd5:    c = 8'h20;
         default: c = 8'h48;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/hhe_host_ram.sv =====
// host name buffer: one write port, one registered read port
module hhe_host_ram
   import hhe_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [HOST_MAX];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hhe_parser.sv =====
// frame header parser and payload scanner, writes host bytes into the buffer
module hhe_parser
   import hhe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [31:0]       csr_data,
   input  logic              byte_accept,
   input  logic [7:0]        frame_byte,
   input  logic              frame_end,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [7:0]        wr_data,
   output emit_cmd_type      cmd
);

   localparam logic [POS_W-1:0] POS_IHL   = POS_W'(LINK_HEADER_BYTES);
   localparam logic [POS_W-1:0] POS_PROTO = POS_W'(LINK_HEADER_BYTES + 9);
   localparam logic [POS_W-1:0] POS_SRC0  = POS_W'(LINK_HEADER_BYTES + 12);
   localparam logic [POS_W-1:0] POS_SRC3  = POS_W'(LINK_HEADER_BYTES + 15);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FRAME_MAX);

   logic [31:0]      src_addr_ff,  src_addr_in;
   logic [POS_W-1:0] pos_ff,       pos_in;
   logic [3:0]       ihl_ff,       ihl_in;
   logic [POS_W-1:0] pstart_ff,    pstart_in;
   logic             src_match_ff, src_match_in;
   logic             is_tcp_ff,    is_tcp_in;
   logic             term_ff,      term_in;
   logic [1:0]       http_prog_ff, http_prog_in;
   logic             http_seen_ff, http_seen_in;
   logic [2:0]       host_prog_ff, host_prog_in;
   host_phase_type   phase_ff,     phase_in;
   logic [LEN_W-1:0] host_cnt_ff,  host_cnt_in;
   logic             overflow_ff,  overflow_in;

   logic [POS_W-1:0] tcp_off_pos;
   logic [POS_W-1:0] src_idx_full;
   logic [1:0]       src_idx;
   logic [7:0]       src_byte;
   logic             src_eq;

   // configuration register
   always_comb begin
      src_addr_in = src_addr_ff;
      if (csr_valid) begin
         src_addr_in = csr_data;
      end
   end

   // source byte select, first wire byte is the top byte
   always_comb begin
      tcp_off_pos  = POS_SRC0 + POS_W'({ihl_ff, 2'b00});
      src_idx_full = pos_ff - POS_SRC0;
      src_idx      = src_idx_full[1:0];
      case (src_idx)
         2'd0:    src_byte = src_addr_ff[31:24];
         2'd1:    src_byte = src_addr_ff[23:16];
         2'd2:    src_byte = src_addr_ff[15:8];
         default: src_byte = src_addr_ff[7:0];
      endcase
      src_eq = (src_byte == frame_byte);
   end

   // per-byte state update
   always_comb begin
      pos_in       = pos_ff;
      ihl_in       = ihl_ff;
      pstart_in    = pstart_ff;
      src_match_in = src_match_ff;
      is_tcp_in    = is_tcp_ff;
      term_in      = term_ff;
      http_prog_in = http_prog_ff;
      http_seen_in = http_seen_ff;
      host_prog_in = host_prog_ff;
      phase_in     = phase_ff;
      host_cnt_in  = host_cnt_ff;
      overflow_in  = overflow_ff;
      wr_en        = 1'b0;
      wr_addr      = host_cnt_ff[ADDR_W-1:0];
      wr_data      = frame_byte;
      cmd          = '0;

      if (byte_accept && (pos_ff < POS_LIMIT)) begin
         pos_in = pos_ff + POS_W'(1);

         // ip header fields
         if (pos_ff == POS_IHL) begin
            ihl_in = frame_byte[3:0];
         end
         if (pos_ff == POS_PROTO) begin
            is_tcp_in = (frame_byte == PROTO_TCP);
         end
         if ((pos_ff >= POS_SRC0) && (pos_ff <= POS_SRC3)) begin
            src_match_in = (pos_ff == POS_SRC0) ? src_eq : (src_match_ff && src_eq);
         end

         // tcp data offset byte, payload follows it
         if ((pos_ff > POS_IHL) && (pos_ff == tcp_off_pos) && (pstart_ff == '0)) begin
            if (frame_byte[7:4] >= 4'd4) begin
               pstart_in = POS_IHL + POS_W'({ihl_ff, 2'b00})
                         + POS_W'({frame_byte[7:4], 2'b00});
            end
         end else if ((pstart_ff != '0) && (pos_ff >= pstart_ff) && !term_ff) begin
            if (frame_byte == 8'h00) begin
               term_in = 1'b1;
            end else begin
               // "HTTP" watch
               if (!http_seen_ff) begin
                  if (frame_byte == http_char(http_prog_ff)) begin
                     if (http_prog_ff == 2'd3) begin
                        http_seen_in = 1'b1;
                        http_prog_in = 2'd0;
                     end else begin
                        http_prog_in = http_prog_ff + 2'd1;
                     end
                  end else begin
                     http_prog_in = (frame_byte == CHAR_H) ? 2'd1 : 2'd0;
                  end
               end

               // "Host: " search and capture
               unique case (phase_ff)
                  PHASE_SEARCHING: begin
                     if (frame_byte == host_char(host_prog_ff)) begin
                        if (host_prog_ff >= 3'd5) begin
                           phase_in     = PHASE_CAPTURING;
                           host_prog_in = 3'd0;
                        end else begin
                           host_prog_in = host_prog_ff + 3'd1;
                        end
                     end else begin
                        host_prog_in = (frame_byte == CHAR_H) ? 3'd1 : 3'd0;
                     end
                  end
                  PHASE_CAPTURING: begin
                     if (frame_byte == CHAR_CR) begin
                        phase_in = PHASE_DONE;
                     end else if (host_cnt_ff < LEN_W'(HOST_MAX)) begin
                        wr_en       = 1'b1;
                        host_cnt_in = host_cnt_ff + LEN_W'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  PHASE_DONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
      end

      // frame end: decide on emission, then clear the frame
      if (byte_accept && frame_end) begin
         cmd.start    = src_match_in && is_tcp_in && http_seen_in && (phase_in == PHASE_DONE);
         cmd.single   = overflow_in || (host_cnt_in == '0);
         cmd.too_long = overflow_in;
         cmd.count    = host_cnt_in;
         pos_in       = '0;
         ihl_in       = '0;
         pstart_in    = '0;
         src_match_in = 1'b0;
         is_tcp_in    = 1'b0;
         term_in      = 1'b0;
         http_prog_in = '0;
         http_seen_in = 1'b0;
         host_prog_in = '0;
         phase_in     = PHASE_SEARCHING;
         host_cnt_in  = '0;
         overflow_in  = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_addr_ff  <= SRC_RESET;
         pos_ff       <= '0;
         ihl_ff       <= '0;
         pstart_ff    <= '0;
         src_match_ff <= 1'b0;
         is_tcp_ff    <= 1'b0;
         term_ff      <= 1'b0;
         http_prog_ff <= '0;
         http_seen_ff <= 1'b0;
         host_prog_ff <= '0;
         phase_ff     <= PHASE_SEARCHING;
         host_cnt_ff  <= '0;
         overflow_ff  <= 1'b0;
      end else begin
         src_addr_ff  <= src_addr_in;
         pos_ff       <= pos_in;
         ihl_ff       <= ihl_in;
         pstart_ff    <= pstart_in;
         src_match_ff <= src_match_in;
         is_tcp_ff    <= is_tcp_in;
         term_ff      <= term_in;
         http_prog_ff <= http_prog_in;
         http_seen_ff <= http_seen_in;
         host_prog_ff <= host_prog_in;
         phase_ff     <= phase_in;
         host_cnt_ff  <= host_cnt_in;
         overflow_ff  <= overflow_in;
      end
   end

endmodule

// ===== rtl/hhe_emitter.sv =====
// result sequencer: reads the host buffer and drives the result register
module hhe_emitter
   import hhe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  emit_cmd_type      cmd,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output logic              busy,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);

   emit_state_type   state_ff,     state_in;
   logic [LEN_W-1:0] count_ff,     count_in;
   logic [LEN_W-1:0] issue_ff,     issue_in;
   logic             rd_valid_ff,  rd_valid_in;
   logic             rd_last_ff,   rd_last_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_data_ff,  out_data_in;
   logic             out_last_ff,  out_last_in;
   logic             out_user_ff,  out_user_in;

   logic out_free;
   logic move;
   logic issue;

   // read issue and read-data stage
   always_comb begin
      out_free = !out_valid_ff || rsp_tready;
      move     = rd_valid_ff && out_free;
      issue    = (state_ff == EMIT_RUN) && (issue_ff < count_ff) && (!rd_valid_ff || move);
      rd_en    = issue;
      rd_addr  = issue_ff[ADDR_W-1:0];

      rd_valid_in = rd_valid_ff;
      rd_last_in  = rd_last_ff;
      issue_in    = issue_ff;
      if (issue) begin
         rd_valid_in = 1'b1;
         rd_last_in  = ((issue_ff + LEN_W'(1)) == count_ff);
         issue_in    = issue_ff + LEN_W'(1);
      end else if (move) begin
         rd_valid_in = 1'b0;
      end

      // a new run reads from entry zero
      if ((state_ff == EMIT_IDLE) && cmd.start) begin
         issue_in = '0;
      end
   end

   // output register and sequencer
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_user_in  = out_user_ff;
      state_in     = state_ff;
      count_in     = count_ff;

      if (move) begin
         out_valid_in = 1'b1;
         out_data_in  = rd_data;
         out_last_in  = rd_last_ff;
         out_user_in  = 1'b0;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         EMIT_IDLE: begin
            if (cmd.start) begin
               state_in = EMIT_RUN;
               if (cmd.single) begin
                  // empty or overlong host: one flag word
                  count_in     = '0;
                  out_valid_in = 1'b1;
                  out_data_in  = 8'h00;
                  out_last_in  = 1'b1;
                  out_user_in  = cmd.too_long;
               end else begin
                  count_in = cmd.count;
               end
            end
         end
         EMIT_RUN: begin
            if (out_valid_ff && rsp_tready && out_last_ff) begin
               state_in = EMIT_IDLE;
            end
         end
         default: begin
            state_in = EMIT_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EMIT_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_last_ff  <= rd_last_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_user_ff <= out_user_in;
   end

   assign busy       = (state_ff == EMIT_RUN);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// ===== rtl/http_host_extractor.sv =====
// http host extractor top level
// Takes an Ethernet frame one byte per word on req_, one word per cycle while the
// frame streams and req_tready is high, and on the frame's last byte gives the Host
// header value on rsp_ when the IPv4 source matches the csr_ address, the protocol
// is TCP, "HTTP" was seen in the payload and the host ended in a carriage return.
// Host bytes go into a 64-entry buffer memory with a registered read; emitting
// them through that read and the result register holds off req_ until the last
// is taken, one result per cycle while rsp_tready is high; an empty or overlong
// host gives one flag word and a pause. Frames that give no result cause no pause.
module http_host_extractor
   import hhe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] host_char
   output logic        rsp_tlast,   // host_last
   output logic        rsp_tuser,   // [0] host_too_long
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // source_filter_address
);

   logic              byte_accept;
   logic              busy;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   emit_cmd_type      cmd;

   // input held off while results are going out
   assign req_tready  = !busy;
   assign csr_ready   = 1'b1;
   assign byte_accept = req_tvalid && req_tready;

   hhe_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .byte_accept (byte_accept),
      .frame_byte  (req_tdata),
      .frame_end   (req_tlast),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .cmd         (cmd)
   );

   hhe_host_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hhe_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/hhe_checker.sv =====
// port-level checker for the http host extractor, bound to the top level
`include "http_host_extractor_defines.svh"

module hhe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // a stalled result word holds
   `HHE_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "result word changed under stall")

   // no frame byte taken while results are pending
   `HHE_ASSERT_IMP(a_req_blocked, rsp_tvalid, !req_tready, "input accepted during emission")

   // overflow flag word is a last word with zero data
   `HHE_ASSERT_IMP(a_flag_word, rsp_tvalid && rsp_tuser, rsp_tlast && (rsp_tdata == 8'h00), "bad overflow word")

   // a new frame needs at least one accepted byte before more results
   `HHE_ASSERT_NXT(a_gap_after_last, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid, "result right after last word")

endmodule

bind http_host_extractor hhe_checker u_checker (.*);
